// ===== design/tensor_region_pack_translate_unit_assert.svh =====
// Assertion macros for the packed-region translator.
`ifndef TENSOR_REGION_PACK_TRANSLATE_UNIT_ASSERT_SVH
`define TENSOR_REGION_PACK_TRANSLATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TRPT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define TRPT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TRPT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define TRPT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== design/trpt_pkg.sv =====
// Shared types and constants of the packed-region translator.
`default_nettype none
package trpt_pkg;
  localparam int WORD_W = 32;
  localparam int DIV_LAT = WORD_W + 2;

  localparam int SIZE_W = 16;
  localparam int OFF_W = 31;
  localparam int AREA_W = 24;
  localparam int CHAN_W = 16;
  localparam int BATCH_W = 16;
  localparam int PW_W = 5;
  localparam int SWAP_W = 2;

  localparam int S_DATA_W = 296;
  localparam int M_DATA_W = 344;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam int PW_RESET = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_AREA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_CHANNELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_BATCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_AREA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BATCH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PACK_WIDTH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_MODE = 3'd7;

  localparam logic [SWAP_W-1:0] SWAP_BATCH_CHAN = 2'd1;
  localparam logic [SWAP_W-1:0] SWAP_CHAN_AREA = 2'd2;

  typedef logic [WORD_W-1:0] word_t;
endpackage
`default_nettype wire

// ===== design/trpt_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none
module trpt_div (
  input  logic           clk,
  input  logic           en,
  input  trpt_pkg::word_t num,
  input  trpt_pkg::word_t den,
  output trpt_pkg::word_t quo,
  output trpt_pkg::word_t rem
);
  import trpt_pkg::*;

  typedef struct packed {
    word_t r;
    word_t n;
    word_t b;
    word_t a;
    logic  neg_q;
    logic  neg_r;
    logic  zero;
  } div_stage_t;

  div_stage_t st [WORD_W+1];
  div_stage_t entry;

  function automatic div_stage_t div_step(input div_stage_t s);
    logic [WORD_W:0] t;
    logic [WORD_W:0] d;
    div_stage_t o;
    o = s;
    t = {s.r, s.n[WORD_W-1]};
    d = t - {1'b0, s.b};
    if (!d[WORD_W]) begin
      o.r = d[WORD_W-1:0];
      o.n = {s.n[WORD_W-2:0], 1'b1};
    end else begin
      o.r = t[WORD_W-1:0];
      o.n = {s.n[WORD_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    entry.r = '0;
    entry.n = num[WORD_W-1] ? WORD_W'(~num + WORD_W'(1)) : num;
    entry.b = den[WORD_W-1] ? WORD_W'(~den + WORD_W'(1)) : den;
    entry.a = num;
    entry.neg_q = num[WORD_W-1] ^ den[WORD_W-1];
    entry.neg_r = num[WORD_W-1];
    entry.zero = (den == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= entry;
      for (int k = 0; k < WORD_W; k++) begin
        st[k+1] <= div_step(st[k]);
      end
      if (st[WORD_W].zero) begin
        quo <= '0;
        rem <= st[WORD_W].a;
      end else begin
        quo <= st[WORD_W].neg_q ? WORD_W'(~st[WORD_W].n + WORD_W'(1)) : st[WORD_W].n;
        rem <= st[WORD_W].neg_r ? WORD_W'(~st[WORD_W].r + WORD_W'(1)) : st[WORD_W].r;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/tensor_region_pack_translate_unit.sv =====
// Top level of the packed-region translator: feasibility check and descriptor translation.
//
// Usage: a request on s_* carries one three-axis copy descriptor in plain
// batch-channel-area layout; the result on m_* carries fast_ok and the
// descriptor translated to the channel-packed layout. Tensor shapes, pack
// width and swap mode come from the cfg_* write port. The user writes them while
// no request is in flight; the block itself does not enforce this.
// Pipeline: an accepted request passes one input stage, three chained divider
// phases, one product stage and the output register before m_tvalid.
// The divider phases retire one quotient bit per stage.
// Throughput: one request per cycle while the output is not stalled.
// Reset: clears every valid bit and returns the shape registers to 1, the
// pack width to 4 and the swap mode to plain.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready is low; nothing is dropped or repeated.
`default_nettype none
`include "tensor_region_pack_translate_unit_assert.svh"
module tensor_region_pack_translate_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // size_0, size_1, size_2, src_offset, src_stride_0..2, dst_offset, dst_stride_0..2
  input  logic [trpt_pkg::S_DATA_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // fast_ok, packed_size_0..2, packed_src_offset, packed_src_stride_0..2,
  // packed_dst_offset, packed_dst_stride_0..2, two zero bits
  output logic [trpt_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                               cfg_we,
  input  logic [trpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trpt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trpt_pkg::*;

  localparam int NB = 16;
  localparam int NC = 8;
  localparam int ND = 26;
  localparam int SOFF_LSB = 3 * SIZE_W;
  localparam int SSTR_LSB = SOFF_LSB + OFF_W;
  localparam int DOFF_LSB = SSTR_LSB + 3 * OFF_W;
  localparam int DSTR_LSB = DOFF_LSB + OFF_W;
  localparam int PSZ_LSB = 1;
  localparam int PSOFF_LSB = PSZ_LSB + 3 * OFF_W;
  localparam int PSSTR_LSB = PSOFF_LSB + OFF_W;
  localparam int PDOFF_LSB = PSSTR_LSB + 3 * OFF_W;
  localparam int PDSTR_LSB = PDOFF_LSB + OFF_W;

  typedef struct packed {
    logic [2:0][SIZE_W-1:0] size;
    logic [2:0][OFF_W-1:0]  ss;
    logic [2:0][OFF_W-1:0]  ds;
  } ctx_b_t;

  typedef struct packed {
    logic [2:0][SIZE_W-1:0] size;
    logic [2:0][OFF_W-1:0]  ss;
    logic [2:0][OFF_W-1:0]  ds;
    logic [7:0][WORD_W-1:0] in_p;
    logic [5:0][WORD_W-1:0] sa;
    logic [1:0][WORD_W-1:0] ab;
    logic [1:0][WORD_W-1:0] pa;
    logic [1:0][WORD_W-1:0] ca;
  } ctx_c_t;

  typedef struct packed {
    logic [2:0][SIZE_W-1:0] size;
    logic [2:0][OFF_W-1:0]  ss;
    logic [2:0][OFF_W-1:0]  ds;
    logic [1:0][WORD_W-1:0] off_in;
    logic [1:0][WORD_W-1:0] off_ax;
    logic [1:0][WORD_W-1:0] off_out;
    logic [5:0][WORD_W-1:0] sa;
    logic [1:0][WORD_W-1:0] ab;
    logic [1:0][WORD_W-1:0] pa;
    logic [1:0][WORD_W-1:0] ca;
    logic [1:0][WORD_W-1:0] cpa;
    logic [5:0]             fnc;
    logic [5:0]             fnw;
    logic [5:0]             fcw;
    logic [2:0]             posax;
    logic                   ok_ax;
  } ctx_d_t;

  function automatic logic pos(input word_t v);
    return !v[WORD_W-1] && (v != '0);
  endfunction

  function automatic logic part_side(input int k);
    return (k == 1) || (k >= 5);
  endfunction

  function automatic logic fuse_ok(input logic pi, input logic pa, input logic po,
                                   input word_t ax, input word_t out_v,
                                   input word_t chan, input word_t batch,
                                   input logic snc_i, input logic scw_i, input logic full_i);
    logic ok;
    ok = 1'b1;
    if (snc_i) begin
      if (pa && pi && full_i) ok = 1'b0;
      if (pa && po && (WORD_W'(out_v + WORD_W'(1)) != batch)) ok = 1'b0;
    end else if (scw_i) begin
      if (pa && po && full_i) ok = 1'b0;
      if (pa && pi && (WORD_W'(ax + WORD_W'(1)) != chan)) ok = 1'b0;
    end else if (pi && po && full_i) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  // configuration
  logic [AREA_W-1:0]  src_area, dst_area;
  logic [CHAN_W-1:0]  src_channels, dst_channels;
  logic [BATCH_W-1:0] src_batch, dst_batch;
  logic [PW_W-1:0]    pack_width;
  logic [SWAP_W-1:0]  swap_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_area <= AREA_W'(1);
      src_channels <= CHAN_W'(1);
      src_batch <= BATCH_W'(1);
      dst_area <= AREA_W'(1);
      dst_channels <= CHAN_W'(1);
      dst_batch <= BATCH_W'(1);
      pack_width <= PW_W'(PW_RESET);
      swap_mode <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_AREA:     src_area <= cfg_data[AREA_W-1:0];
        REG_SRC_CHANNELS: src_channels <= cfg_data[CHAN_W-1:0];
        REG_SRC_BATCH:    src_batch <= cfg_data[BATCH_W-1:0];
        REG_DST_AREA:     dst_area <= cfg_data[AREA_W-1:0];
        REG_DST_CHANNELS: dst_channels <= cfg_data[CHAN_W-1:0];
        REG_DST_BATCH:    dst_batch <= cfg_data[BATCH_W-1:0];
        REG_PACK_WIDTH:   pack_width <= cfg_data[PW_W-1:0];
        REG_SWAP_MODE:    swap_mode <= cfg_data[SWAP_W-1:0];
        default: ;
      endcase
    end
  end

  word_t area_w [2];
  word_t chan_w [2];
  word_t batch_w [2];
  word_t pw_w;
  logic  snc, scw;
  logic  full [2];

  always_comb begin
    area_w[0] = WORD_W'(src_area);
    area_w[1] = WORD_W'(dst_area);
    chan_w[0] = WORD_W'(src_channels);
    chan_w[1] = WORD_W'(dst_channels);
    batch_w[0] = WORD_W'(src_batch);
    batch_w[1] = WORD_W'(dst_batch);
    pw_w = WORD_W'(pack_width);
    snc = (swap_mode == SWAP_BATCH_CHAN);
    scw = (swap_mode == SWAP_CHAN_AREA);
    for (int x = 0; x < 2; x++) begin
      full[x] = (area_w[x] > WORD_W'(1)) && (chan_w[x] > WORD_W'(1)) &&
                (batch_w[x] > WORD_W'(1));
    end
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: unpack, form last-element displacements
  logic [2:0][SIZE_W-1:0] in_size;
  logic [2:0][OFF_W-1:0]  in_ss, in_ds;
  word_t                  in_step [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_size[i] = s_tdata[SIZE_W*i +: SIZE_W];
      in_ss[i] = s_tdata[SSTR_LSB + OFF_W*i +: OFF_W];
      in_ds[i] = s_tdata[DSTR_LSB + OFF_W*i +: OFF_W];
      in_step[i] = WORD_W'(in_size[i]) - WORD_W'(1);
    end
  end

  logic                   a_vld;
  logic [2:0][SIZE_W-1:0] a_size;
  logic [2:0][OFF_W-1:0]  a_ss, a_ds;
  logic [OFF_W-1:0]       a_soff, a_doff;
  word_t                  a_vs [3];
  word_t                  a_vd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_size <= in_size;
      a_ss <= in_ss;
      a_ds <= in_ds;
      a_soff <= s_tdata[SOFF_LSB +: OFF_W];
      a_doff <= s_tdata[DOFF_LSB +: OFF_W];
      for (int i = 0; i < 3; i++) begin
        a_vs[i] <= WORD_W'(in_step[i] * WORD_W'(in_ss[i]));
        a_vd[i] <= WORD_W'(in_step[i] * WORD_W'(in_ds[i]));
      end
    end
  end

  // phase B: divide by area, chunk counts
  word_t b_num [NB];
  word_t b_den [NB];
  word_t b_q [NB];
  word_t b_r [NB];

  always_comb begin
    b_num[0] = WORD_W'(a_soff);
    b_den[0] = area_w[0];
    b_num[1] = WORD_W'(a_doff);
    b_den[1] = area_w[1];
    for (int i = 0; i < 3; i++) begin
      b_num[2+i] = a_vs[i];
      b_den[2+i] = area_w[0];
      b_num[5+i] = a_vd[i];
      b_den[5+i] = area_w[1];
      b_num[8+i] = WORD_W'(a_ss[i]);
      b_den[8+i] = area_w[0];
      b_num[11+i] = WORD_W'(a_ds[i]);
      b_den[11+i] = area_w[1];
    end
    b_num[14] = WORD_W'(chan_w[0] + pw_w - WORD_W'(1));
    b_den[14] = pw_w;
    b_num[15] = WORD_W'(chan_w[1] + pw_w - WORD_W'(1));
    b_den[15] = pw_w;
  end

  for (genvar g = 0; g < NB; g++) begin : g_div_b
    trpt_div u_div (
      .clk (clk), .en (en), .num (b_num[g]), .den (b_den[g]), .quo (b_q[g]), .rem (b_r[g])
    );
  end

  ctx_b_t               b_in;
  ctx_b_t               b_pipe [DIV_LAT];
  logic [DIV_LAT-1:0]   b_vld;
  ctx_b_t               b_end;

  always_comb begin
    b_in.size = a_size;
    b_in.ss = a_ss;
    b_in.ds = a_ds;
  end
  assign b_end = b_pipe[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= '0;
    end else if (en) begin
      b_vld <= {b_vld[DIV_LAT-2:0], a_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_pipe[0] <= b_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        b_pipe[k] <= b_pipe[k-1];
      end
    end
  end

  // phase C: divide by channels
  word_t c_num [NC];
  word_t c_den [NC];
  word_t c_q [NC];
  word_t c_r [NC];
  ctx_c_t c_in;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      c_num[k] = b_q[k];
      c_den[k] = chan_w[part_side(k)];
      c_in.in_p[k] = b_r[k];
    end
    for (int j = 0; j < 6; j++) begin
      c_in.sa[j] = b_q[8+j];
    end
    for (int x = 0; x < 2; x++) begin
      c_in.ab[x] = WORD_W'(area_w[x] * batch_w[x]);
      c_in.pa[x] = WORD_W'(area_w[x] * pw_w);
      c_in.ca[x] = WORD_W'(b_q[14+x] * area_w[x]);
    end
    c_in.size = b_end.size;
    c_in.ss = b_end.ss;
    c_in.ds = b_end.ds;
  end

  for (genvar g = 0; g < NC; g++) begin : g_div_c
    trpt_div u_div (
      .clk (clk), .en (en), .num (c_num[g]), .den (c_den[g]), .quo (c_q[g]), .rem (c_r[g])
    );
  end

  ctx_c_t               c_pipe [DIV_LAT];
  logic [DIV_LAT-1:0]   c_vld;
  ctx_c_t               c_end;
  assign c_end = c_pipe[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= '0;
    end else if (en) begin
      c_vld <= {c_vld[DIV_LAT-2:0], b_vld[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_pipe[0] <= c_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        c_pipe[k] <= c_pipe[k-1];
      end
    end
  end

  // phase D: alignment remainders, packed sizes, per-step parts
  word_t  d_num [ND];
  word_t  d_den [ND];
  word_t  d_q [ND];
  word_t  d_r [ND];
  word_t  d_step [3];
  ctx_d_t d_in;
  logic   pi, pa, po;
  logic   ok_ax;
  int     p, base, j;

  always_comb begin
    d_num[0] = c_r[0];
    d_den[0] = pw_w;
    d_num[1] = c_r[1];
    d_den[1] = pw_w;
    ok_ax = 1'b1;
    d_in.fnc = '0;
    d_in.fnw = '0;
    d_in.fcw = '0;
    for (int i = 0; i < 3; i++) begin
      d_step[i] = WORD_W'(c_end.size[i]) - WORD_W'(1);
      d_num[2+i] = WORD_W'(c_end.size[i]);
      d_den[2+i] = WORD_W'(c_r[5+i] + WORD_W'(1));
      d_num[5+i] = WORD_W'(c_r[5+i] + pw_w);
      d_den[5+i] = pw_w;
      d_in.posax[i] = pos(c_r[5+i]);
      if (c_r[2+i] != c_r[5+i]) ok_ax = 1'b0;
      for (int x = 0; x < 2; x++) begin
        p = 2 + 3 * x + i;
        j = 3 * x + i;
        base = 8 + 3 * j;
        d_num[base] = c_end.in_p[p];
        d_num[base+1] = c_r[p];
        d_num[base+2] = c_q[p];
        d_den[base] = d_step[i];
        d_den[base+1] = d_step[i];
        d_den[base+2] = d_step[i];
        pi = pos(c_end.in_p[p]);
        pa = pos(c_r[p]);
        po = pos(c_q[p]);
        d_in.fnc[j] = pa && po;
        d_in.fnw[j] = pi && po;
        d_in.fcw[j] = pa && pi;
        if (!fuse_ok(pi, pa, po, c_r[p], c_q[p], chan_w[x], batch_w[x], snc, scw, full[x]))
          ok_ax = 1'b0;
      end
    end
    d_in.ok_ax = ok_ax;
    d_in.size = c_end.size;
    d_in.ss = c_end.ss;
    d_in.ds = c_end.ds;
    d_in.sa = c_end.sa;
    d_in.ab = c_end.ab;
    d_in.pa = c_end.pa;
    d_in.ca = c_end.ca;
    for (int x = 0; x < 2; x++) begin
      d_in.off_in[x] = c_end.in_p[x];
      d_in.off_ax[x] = c_r[x];
      d_in.off_out[x] = c_q[x];
      d_in.cpa[x] = WORD_W'(c_end.ca[x] * pw_w);
    end
  end

  for (genvar g = 0; g < ND; g++) begin : g_div_d
    trpt_div u_div (
      .clk (clk), .en (en), .num (d_num[g]), .den (d_den[g]), .quo (d_q[g]), .rem (d_r[g])
    );
  end

  ctx_d_t               d_pipe [DIV_LAT];
  logic [DIV_LAT-1:0]   d_vld;
  ctx_d_t               d_end;
  logic                 d_out_vld;
  assign d_end = d_pipe[DIV_LAT-1];
  assign d_out_vld = d_vld[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= '0;
    end else if (en) begin
      d_vld <= {d_vld[DIV_LAT-2:0], c_vld[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_pipe[0] <= d_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        d_pipe[k] <= d_pipe[k-1];
      end
    end
  end

  // product stage
  word_t e_m1_next [6];
  word_t e_m2_next [6];
  word_t e_it_next [6];
  word_t e_psz_next [3];
  word_t e_om1_next [2];
  word_t e_om2_next [2];
  word_t e_om3_next [2];
  word_t sel_in, sel_ax, sel_out, stride_v;
  int    ej, eb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_psz_next[i] = d_end.posax[i] ? WORD_W'(d_q[2+i] * d_q[5+i])
                                     : WORD_W'(d_end.size[i]);
      for (int x = 0; x < 2; x++) begin
        ej = 3 * x + i;
        eb = 8 + 3 * ej;
        sel_in = d_q[eb];
        sel_ax = d_q[eb+1];
        sel_out = d_q[eb+2];
        stride_v = (x == 1) ? WORD_W'(d_end.ds[i]) : WORD_W'(d_end.ss[i]);
        if (d_end.fnc[ej]) begin
          if (snc) begin
            sel_ax = '0;
            sel_out = d_end.sa[ej];
          end else begin
            sel_out = '0;
            sel_ax = d_end.sa[ej];
          end
        end else if (d_end.fnw[ej]) begin
          sel_out = '0;
          sel_in = stride_v;
        end else if (d_end.fcw[ej]) begin
          sel_ax = '0;
          sel_in = stride_v;
        end
        if (d_end.size[i] <= SIZE_W'(1)) begin
          e_m1_next[ej] = '0;
          e_m2_next[ej] = '0;
          e_it_next[ej] = '0;
        end else begin
          e_m1_next[ej] = snc ? WORD_W'(sel_out * area_w[x])
                              : WORD_W'(sel_out * d_end.ca[x]);
          e_m2_next[ej] = snc ? WORD_W'(sel_ax * d_end.ab[x])
                              : WORD_W'(sel_ax * area_w[x]);
          e_it_next[ej] = sel_in;
        end
      end
    end
    for (int x = 0; x < 2; x++) begin
      e_om1_next[x] = snc ? WORD_W'(d_end.off_out[x] * d_end.pa[x])
                          : WORD_W'(d_end.off_out[x] * d_end.cpa[x]);
      e_om2_next[x] = snc ? WORD_W'(d_end.off_ax[x] * d_end.ab[x])
                          : WORD_W'(d_end.off_ax[x] * area_w[x]);
      e_om3_next[x] = WORD_W'(d_end.off_in[x] * pw_w);
    end
  end

  logic  e_vld, e_ok;
  word_t e_m1 [6];
  word_t e_m2 [6];
  word_t e_it [6];
  word_t e_psz [3];
  word_t e_om1 [2];
  word_t e_om2 [2];
  word_t e_om3 [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_out_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ok <= d_end.ok_ax && (d_r[0] == '0) && (d_r[1] == '0);
      e_m1 <= e_m1_next;
      e_m2 <= e_m2_next;
      e_it <= e_it_next;
      e_psz <= e_psz_next;
      e_om1 <= e_om1_next;
      e_om2 <= e_om2_next;
      e_om3 <= e_om3_next;
    end
  end

  // output register
  logic [M_DATA_W-1:0] m_tdata_next;
  word_t               sum_v;

  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[0] = e_ok;
    for (int i = 0; i < 3; i++) begin
      m_tdata_next[PSZ_LSB + OFF_W*i +: OFF_W] = e_psz[i][OFF_W-1:0];
      sum_v = WORD_W'(e_m1[i] + e_m2[i] + e_it[i]);
      m_tdata_next[PSSTR_LSB + OFF_W*i +: OFF_W] = sum_v[OFF_W-1:0];
      sum_v = WORD_W'(e_m1[3+i] + e_m2[3+i] + e_it[3+i]);
      m_tdata_next[PDSTR_LSB + OFF_W*i +: OFF_W] = sum_v[OFF_W-1:0];
    end
    sum_v = WORD_W'(e_om1[0] + e_om2[0] + e_om3[0]);
    m_tdata_next[PSOFF_LSB +: OFF_W] = sum_v[OFF_W-1:0];
    sum_v = WORD_W'(e_om1[1] + e_om2[1] + e_om3[1]);
    m_tdata_next[PDOFF_LSB +: OFF_W] = sum_v[OFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= e_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= m_tdata_next;
    end
  end

  `TRPT_IMPLY(a_hold_only_on_stall, clk, rst, !s_tready, m_tvalid && !m_tready)
  `TRPT_NEXT(a_misaligned_offset_fails, clk, rst, d_out_vld && en && (d_r[0] != '0), !e_ok)
  `TRPT_NEXT(a_short_axis_zero, clk, rst, d_out_vld && en && (d_end.size[0] <= SIZE_W'(1)), (e_m1[0] == '0) && (e_m2[0] == '0) && (e_it[0] == '0))
endmodule
`default_nettype wire

// ===== sim/tb_tensor_region_pack_translate_unit.sv =====
// Testbench for the packed-region translator: checks every result against a predictor.
`default_nettype none
module tb_tensor_region_pack_translate_unit;
  import trpt_pkg::*;

  localparam int LATENCY = 105;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 780;

  typedef struct {
    bit [15:0] size [3];
    bit [30:0] src_off;
    bit [30:0] src_stride [3];
    bit [30:0] dst_off;
    bit [30:0] dst_stride [3];
  } region_t;

  typedef struct {
    bit [31:0] area;
    bit [31:0] chan;
    bit [31:0] batch;
  } shape_t;

  typedef struct {
    bit [31:0] inner;
    bit [31:0] ax;
    bit [31:0] outer;
  } parts_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_DATA_W-1:0] m_tdata;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit [31:0] regs [8];
  bit [M_DATA_W-1:0] packed_expect_q [$];
  bit no_idle = 0;
  int fail_count = 0;
  int cycle_count = 0;

  tensor_region_pack_translate_unit uut (.*);

  always #2 clk = ~clk;

  function automatic longint sx(bit [31:0] u);
    return longint'(signed'(u));
  endfunction

  function automatic bit [31:0] div_q(bit [31:0] a, bit [31:0] b);
    if (sx(b) == 0) return 0;
    return 32'(sx(a) / sx(b));
  endfunction

  function automatic bit [31:0] div_r(bit [31:0] a, bit [31:0] b);
    if (sx(b) == 0) return a;
    return 32'(sx(a) % sx(b));
  endfunction

  function automatic bit is_pos(bit [31:0] v);
    return sx(v) > 0;
  endfunction

  function automatic parts_t split_disp(bit [31:0] v, shape_t s);
    parts_t p;
    bit [31:0] t;
    t = div_q(v, s.area);
    p.inner = div_r(v, s.area);
    p.ax = div_r(t, s.chan);
    p.outer = div_q(t, s.chan);
    return p;
  endfunction

  function automatic bit fused_nc(parts_t p);
    return is_pos(p.ax) && is_pos(p.outer);
  endfunction

  function automatic bit fused_cw(parts_t p);
    return is_pos(p.ax) && is_pos(p.inner);
  endfunction

  function automatic bit fused_nw(parts_t p);
    return is_pos(p.inner) && is_pos(p.outer);
  endfunction

  function automatic bit fusion_legal(parts_t p, shape_t s, bit snc, bit scw, bit full);
    if (snc) begin
      if (fused_cw(p) && full) return 0;
      if (fused_nc(p) && p.outer + 32'd1 != s.batch) return 0;
    end else if (scw) begin
      if (fused_nc(p) && full) return 0;
      if (fused_cw(p) && p.ax + 32'd1 != s.chan) return 0;
    end else begin
      if (fused_nw(p) && full) return 0;
    end
    return 1;
  endfunction

  function automatic bit [31:0] ceil_div(bit [31:0] x, bit [31:0] d);
    return div_q(x + d - 32'd1, d);
  endfunction

  function automatic bit [31:0] pack_stride(parts_t p, shape_t s, bit [31:0] step, bit snc,
                                            bit [31:0] stride, bit [31:0] chunks);
    bit [31:0] i, a, o;
    i = div_q(p.inner, step);
    a = div_q(p.ax, step);
    o = div_q(p.outer, step);
    if (fused_nc(p)) begin
      if (snc) begin
        a = 0;
        o = div_q(stride, s.area);
      end else begin
        o = 0;
        a = div_q(stride, s.area);
      end
    end else if (fused_nw(p)) begin
      o = 0;
      i = stride;
    end else if (fused_cw(p)) begin
      a = 0;
      i = stride;
    end
    if (snc) return o * s.area + a * s.area * s.batch + i;
    return o * chunks * s.area + a * s.area + i;
  endfunction

  function automatic bit [31:0] pack_offset(bit [31:0] off, shape_t s, bit snc,
                                            bit [31:0] chunks, bit [31:0] pw);
    parts_t p;
    p = split_disp(off, s);
    if (snc) return p.outer * pw * s.area + p.ax * s.area * s.batch + p.inner * pw;
    return p.outer * chunks * pw * s.area + p.ax * s.area + p.inner * pw;
  endfunction

  function automatic bit [M_DATA_W-1:0] translate_region(region_t r);
    shape_t s, d;
    parts_t sp, dp;
    bit snc, scw, ok, sfull, dfull;
    bit [31:0] pw, schunks, dchunks, step, psz, pss, pds, n, ss, ds;
    bit [31:0] val [12];
    bit [M_DATA_W-1:0] word;
    s = '{regs[REG_SRC_AREA], regs[REG_SRC_CHANNELS], regs[REG_SRC_BATCH]};
    d = '{regs[REG_DST_AREA], regs[REG_DST_CHANNELS], regs[REG_DST_BATCH]};
    pw = regs[REG_PACK_WIDTH];
    snc = regs[REG_SWAP_MODE] == 32'(SWAP_BATCH_CHAN);
    scw = regs[REG_SWAP_MODE] == 32'(SWAP_CHAN_AREA);
    sfull = s.area > 1 && s.chan > 1 && s.batch > 1;
    dfull = d.area > 1 && d.chan > 1 && d.batch > 1;
    schunks = ceil_div(s.chan, pw);
    dchunks = ceil_div(d.chan, pw);
    ok = 1;
    if (div_r(div_r(div_q(32'(r.src_off), s.area), s.chan), pw) != 0) ok = 0;
    if (div_r(div_r(div_q(32'(r.dst_off), d.area), d.chan), pw) != 0) ok = 0;
    for (int k = 0; k < 3; k++) begin
      if (ok) begin
        step = 32'(r.size[k]) - 32'd1;
        dp = split_disp(step * 32'(r.dst_stride[k]), d);
        sp = split_disp(step * 32'(r.src_stride[k]), s);
        if (dp.ax != sp.ax) ok = 0;
        else if (!fusion_legal(sp, s, snc, scw, sfull)) ok = 0;
        else if (!fusion_legal(dp, d, snc, scw, dfull)) ok = 0;
      end
    end
    val[0] = 32'(ok);
    for (int k = 0; k < 3; k++) begin
      step = 32'(r.size[k]) - 32'd1;
      ss = 32'(r.src_stride[k]);
      ds = 32'(r.dst_stride[k]);
      dp = split_disp(step * ds, d);
      psz = 32'(r.size[k]);
      pss = 0;
      pds = 0;
      if (is_pos(dp.ax)) begin
        n = dp.ax + 32'd1;
        psz = div_q(32'(r.size[k]), n) * ceil_div(n, pw);
      end
      if (r.size[k] > 1) begin
        sp = split_disp(step * ss, s);
        pss = pack_stride(sp, s, step, snc, ss, schunks);
        pds = pack_stride(dp, d, step, snc, ds, dchunks);
      end
      val[1 + k] = psz;
      val[5 + k] = pss;
      val[9 + k] = pds;
    end
    val[4] = pack_offset(32'(r.src_off), s, snc, schunks, pw);
    val[8] = pack_offset(32'(r.dst_off), d, snc, dchunks, pw);
    word = '0;
    word[0] = val[0][0];
    for (int k = 1; k < 12; k++) word[1 + 31*(k-1) +: 31] = val[k][30:0];
    return word;
  endfunction

  function automatic bit [S_DATA_W-1:0] pack_region(region_t r);
    bit [S_DATA_W-1:0] w;
    w = '0;
    for (int k = 0; k < 3; k++) begin
      w[16*k +: 16] = r.size[k];
      w[79 + 31*k +: 31] = r.src_stride[k];
      w[203 + 31*k +: 31] = r.dst_stride[k];
    end
    w[48 +: 31] = r.src_off;
    w[172 +: 31] = r.dst_off;
    return w;
  endfunction

  task automatic send_region(region_t r);
    while (!no_idle && $urandom_range(99) < 26) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pack_region(r);
    do @(posedge clk); while (!s_tready);
    packed_expect_q.push_back(translate_region(r));
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    @(posedge clk);
    while (packed_expect_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic load_config(bit [31:0] v [8]);
    for (int k = 0; k < 8; k++) begin
      cfg_we <= 1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data <= CFG_DATA_W'(v[k]);
      @(posedge clk);
      case (k)
        REG_SRC_AREA, REG_DST_AREA: regs[k] = v[k] & 32'hFFFFFF;
        REG_PACK_WIDTH: regs[k] = v[k] & 32'h1F;
        REG_SWAP_MODE: regs[k] = v[k] & 32'h3;
        default: regs[k] = v[k] & 32'hFFFF;
      endcase
    end
    cfg_we <= 0;
  endtask

  function automatic bit [31:0] pick_dim(bit [31:0] hi);
    case ($urandom_range(9))
      0: return 1;
      1: return hi;
      2, 3: return $urandom_range(2, 4);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic bit [30:0] aligned_offset(bit [31:0] area, bit [31:0] chan, bit [31:0] pw,
                                               bit [31:0] batch);
    bit [31:0] b, c;
    b = $urandom_range(0, batch > 4 ? 3 : batch - 1);
    c = pw * $urandom_range(0, 3);
    if ($urandom_range(7) == 0) c = c + 1;
    return 31'((b * chan + c) * area + $urandom_range(0, area > 8 ? 7 : area - 1));
  endfunction

  function automatic bit [30:0] pick_stride(bit [31:0] area, bit [31:0] chan);
    case ($urandom_range(5))
      0: return 1;
      1: return 31'(area);
      2: return 31'(area * chan);
      3: return 31'(area * $urandom_range(2, 5));
      4: return 0;
      default: return 31'($urandom_range(1, 100));
    endcase
  endfunction

  function automatic region_t random_region();
    region_t r;
    if ($urandom_range(99) < 25) begin
      for (int k = 0; k < 3; k++) begin
        r.size[k] = 16'($urandom);
        r.src_stride[k] = 31'($urandom);
        r.dst_stride[k] = 31'($urandom);
      end
      r.src_off = 31'($urandom);
      r.dst_off = 31'($urandom);
    end else begin
      for (int k = 0; k < 3; k++) begin
        r.size[k] = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        r.src_stride[k] = pick_stride(regs[REG_SRC_AREA], regs[REG_SRC_CHANNELS]);
        r.dst_stride[k] = pick_stride(regs[REG_DST_AREA], regs[REG_DST_CHANNELS]);
      end
      r.src_off = aligned_offset(regs[REG_SRC_AREA], regs[REG_SRC_CHANNELS],
                                 regs[REG_PACK_WIDTH], regs[REG_SRC_BATCH]);
      r.dst_off = aligned_offset(regs[REG_DST_AREA], regs[REG_DST_CHANNELS],
                                 regs[REG_PACK_WIDTH], regs[REG_DST_BATCH]);
    end
    return r;
  endfunction

  function automatic region_t uniform_region(bit [15:0] sz, bit [30:0] off, bit [30:0] st);
    region_t r;
    for (int k = 0; k < 3; k++) begin
      r.size[k] = sz;
      r.src_stride[k] = st;
      r.dst_stride[k] = st;
    end
    r.src_off = off;
    r.dst_off = off;
    return r;
  endfunction

  task automatic test_reset_config();
    send_region(uniform_region(16'd0, 31'd0, 31'd0));
    send_region(uniform_region(16'd1, 31'd4, 31'd1));
    send_region(uniform_region(16'd4, 31'd8, 31'd1));
    send_region(uniform_region(16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
    drain_results();
  endtask

  task automatic test_directed_shapes();
    bit [31:0] v [8];
    region_t r;
    v = '{4, 8, 2, 4, 8, 2, 4, 0};
    load_config(v);
    send_region(uniform_region(16'd2, 31'd0, 31'd1));
    send_region(uniform_region(16'd0, 31'd32, 31'd4));
    send_region(uniform_region(16'd3, 31'd16, 31'd32));
    r = uniform_region(16'd2, 31'd0, 31'd1);
    r.src_stride[1] = 31'd4;
    r.dst_stride[1] = 31'd4;
    r.size[2] = 16'd2;
    r.src_stride[2] = 31'd5;
    r.dst_stride[2] = 31'd5;
    send_region(r);
    r.src_stride[0] = 31'd36;
    r.dst_stride[0] = 31'd36;
    send_region(r);
    r.dst_off = 31'd5;
    send_region(r);
    drain_results();
    for (int m = 1; m < 4; m++) begin
      v[REG_SWAP_MODE] = m;
      load_config(v);
      send_region(uniform_region(16'd2, 31'd0, 31'd36));
      send_region(uniform_region(16'd2, 31'd32, 31'd5));
      send_region(uniform_region(16'd8, 31'd0, 31'd4));
      drain_results();
    end
    v = '{24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16, 1};
    load_config(v);
    send_region(uniform_region(16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_region(uniform_region(16'd2, 31'd0, 31'hFFFFFF));
    drain_results();
    v = '{0, 0, 0, 1, 1, 1, 0, 2};
    load_config(v);
    send_region(uniform_region(16'd3, 31'd7, 31'd2));
    send_region(uniform_region(16'd0, 31'd0, 31'd0));
    drain_results();
  endtask

  task automatic test_random_regions();
    bit [31:0] v [8];
    for (int phase = 0; phase < 8; phase++) begin
      v[REG_SRC_AREA] = pick_dim(24'hFFFFFF);
      v[REG_SRC_CHANNELS] = pick_dim(16'hFFFF);
      v[REG_SRC_BATCH] = pick_dim(16'hFFFF);
      v[REG_DST_AREA] = ($urandom_range(1) == 0) ? v[REG_SRC_AREA] : pick_dim(24'hFFFFFF);
      v[REG_DST_CHANNELS] = pick_dim(16'hFFFF);
      v[REG_DST_BATCH] = pick_dim(16'hFFFF);
      v[REG_PACK_WIDTH] = (phase == 0) ? 1 : (phase == 1) ? 16 : $urandom_range(1, 16);
      v[REG_SWAP_MODE] = phase % 4;
      load_config(v);
      no_idle = (phase == 3);
      for (int k = 0; k < N_RANDOM / 8; k++) send_region(random_region());
      no_idle = 0;
      drain_results();
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    bit [M_DATA_W-1:0] want;
    string field_name;
    m_tready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 26);
    if (!rst && m_tvalid && m_tready) begin
      if (packed_expect_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        fail_count++;
      end else begin
        want = packed_expect_q.pop_front();
        if (want[0] != m_tdata[0]) begin
          $error("fast_ok expected %0d actual %0d", want[0], m_tdata[0]);
          fail_count++;
        end
        for (int k = 1; k < 12; k++) begin
          if (want[1 + 31*(k-1) +: 31] != m_tdata[1 + 31*(k-1) +: 31]) begin
            case (k)
              1, 2, 3: field_name = $sformatf("packed_size_%0d", k - 1);
              4: field_name = "packed_src_offset";
              5, 6, 7: field_name = $sformatf("packed_src_stride_%0d", k - 5);
              8: field_name = "packed_dst_offset";
              default: field_name = $sformatf("packed_dst_stride_%0d", k - 9);
            endcase
            $error("%s expected %0d actual %0d", field_name,
                   want[1 + 31*(k-1) +: 31], m_tdata[1 + 31*(k-1) +: 31]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    regs = '{1, 1, 1, 1, 1, 1, PW_RESET, 0};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_config();
    test_directed_shapes();
    test_random_regions();
    if (fail_count == 0 && packed_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/trpt_pkg.sv
design/trpt_div.sv
design/tensor_region_pack_translate_unit.sv
sim/tb_tensor_region_pack_translate_unit.sv
